/* rtl/core/wsd_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none

package wsd_pkg;

  localparam logic [2:0] KIND_DATA    = 3'd0;
  localparam logic [2:0] KIND_EMPTY   = 3'd1;
  localparam logic [2:0] KIND_PROTO   = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT = 3'd3;
  localparam logic [2:0] KIND_LINK    = 3'd4;

  localparam logic [1:0] CMD_MASK  = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_EVENT = 2'd2;

  localparam logic [3:0]  OPC_CLOSE       = 4'd8;
  localparam logic [6:0]  LEN_EXT16       = 7'd126;
  localparam logic [6:0]  LEN_EXT64       = 7'd127;
  localparam logic [3:0]  EXT16_BYTES     = 4'd2;
  localparam logic [3:0]  EXT64_BYTES     = 4'd8;
  localparam logic [15:0] MAX_FRAME_BYTES = 16'd65535;
  localparam logic [15:0] IDLE_LIMIT_RST  = 16'd15;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] kind;
    logic [7:0] rx_val;
    logic [1:0] key_idx;
    logic       last;
    logic [3:0] opcode;
    logic       closing;
  } wsd_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/wsd_ifs.sv */
// Channel interfaces of the WebSocket frame deframer.
`default_nettype none

interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  modport source (output valid, action, rx_byte, input ready);
  modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       last_in_frame;
  logic [3:0] opcode;
  logic       closing;
  modport source (output valid, kind, data_byte, last_in_frame, opcode, closing, input ready);
  modport sink   (input valid, kind, data_byte, last_in_frame, opcode, closing, output ready);
endinterface

interface wsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/wsd_front.sv */
// Header parser: tracks frame phase and turns items that need a result or a key write into back-end commands.
`default_nettype none

module wsd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  wsd_in_if.sink             in_if,
  wsd_cfg_if.sink            cfg_if,
  input  wire logic          q_ready,
  output logic               push,
  output wsd_pkg::wsd_cmd_t  cmd
);

  localparam logic [2:0] PH_STOPPED = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_HDR2    = 3'd2;
  localparam logic [2:0] PH_EXT     = 3'd3;
  localparam logic [2:0] PH_MASK    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_CLOSED  = 3'd6;

  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_LINK  = 2'd2;
  localparam logic [1:0] ACT_START = 2'd3;

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  opc_r, opc_nxt;
  logic [3:0]  ext_left_r, ext_left_nxt;
  logic [15:0] len_acc_r, len_acc_nxt;
  logic        len_ovf_r, len_ovf_nxt;
  logic [1:0]  mask_idx_r, mask_idx_nxt;
  logic [15:0] pay_left_r, pay_left_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [15:0] idle_limit_r;

  logic        accept;
  logic        active;
  logic [15:0] idle_inc;
  logic [3:0]  ext_dec;
  logic        ovf_now;
  logic [15:0] pay_dec;
  logic        fin_close;

  assign in_if.ready  = q_ready;
  assign cfg_if.ready = 1'b1;
  assign accept       = in_if.valid & q_ready;
  assign active       = (phase_r >= PH_HDR1) && (phase_r <= PH_PAYLOAD);
  assign idle_inc     = (idle_r == 16'hffff) ? idle_r : idle_r + 16'd1;
  assign ext_dec      = (ext_left_r != 4'd0) ? ext_left_r - 4'd1 : ext_left_r;
  assign ovf_now      = len_ovf_r | (len_acc_r[15:8] != 8'd0);
  assign pay_dec      = (pay_left_r != 16'd0) ? pay_left_r - 16'd1 : pay_left_r;
  assign fin_close    = (opc_r == wsd_pkg::OPC_CLOSE);

  always_comb begin
    phase_nxt    = phase_r;
    opc_nxt      = opc_r;
    ext_left_nxt = ext_left_r;
    len_acc_nxt  = len_acc_r;
    len_ovf_nxt  = len_ovf_r;
    mask_idx_nxt = mask_idx_r;
    pay_left_nxt = pay_left_r;
    idle_nxt     = idle_r;
    push         = 1'b0;
    cmd          = '0;
    cmd.cmd      = wsd_pkg::CMD_EVENT;
    cmd.opcode   = opc_r;
    if (accept) begin
      if (in_if.action == ACT_START) begin
        phase_nxt    = PH_HDR1;
        opc_nxt      = 4'd0;
        ext_left_nxt = 4'd0;
        len_acc_nxt  = 16'd0;
        len_ovf_nxt  = 1'b0;
        mask_idx_nxt = 2'd0;
        pay_left_nxt = 16'd0;
        idle_nxt     = 16'd0;
      end else if (active) begin
        if (in_if.action == ACT_LINK) begin
          phase_nxt   = PH_CLOSED;
          push        = 1'b1;
          cmd.kind    = wsd_pkg::KIND_LINK;
          cmd.opcode  = 4'd0;
          cmd.closing = 1'b1;
        end else if (in_if.action == ACT_TICK) begin
          if (phase_r == PH_HDR1 || phase_r == PH_HDR2) begin
            idle_nxt = idle_inc;
            if (idle_inc >= idle_limit_r) begin
              phase_nxt   = PH_CLOSED;
              push        = 1'b1;
              cmd.kind    = wsd_pkg::KIND_TIMEOUT;
              cmd.opcode  = 4'd0;
              cmd.closing = 1'b1;
            end
          end
        end else if (in_if.action == ACT_BYTE) begin
          case (phase_r)
            PH_HDR1: begin
              opc_nxt   = in_if.rx_byte[3:0];
              phase_nxt = PH_HDR2;
            end
            PH_HDR2: begin
              idle_nxt = 16'd0;
              if (!in_if.rx_byte[7]) begin
                phase_nxt   = PH_CLOSED;
                push        = 1'b1;
                cmd.kind    = wsd_pkg::KIND_PROTO;
                cmd.closing = 1'b1;
              end else if (in_if.rx_byte[6:0] == wsd_pkg::LEN_EXT16 ||
                           in_if.rx_byte[6:0] == wsd_pkg::LEN_EXT64) begin
                ext_left_nxt = (in_if.rx_byte[6:0] == wsd_pkg::LEN_EXT16) ?
                               wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;
                len_acc_nxt  = 16'd0;
                len_ovf_nxt  = 1'b0;
                phase_nxt    = PH_EXT;
              end else begin
                pay_left_nxt = {9'd0, in_if.rx_byte[6:0]};
                mask_idx_nxt = 2'd0;
                phase_nxt    = PH_MASK;
              end
            end
            PH_EXT: begin
              len_ovf_nxt  = ovf_now;
              len_acc_nxt  = {len_acc_r[7:0], in_if.rx_byte};
              ext_left_nxt = ext_dec;
              if (ext_dec == 4'd0) begin
                if (ovf_now || ({len_acc_r[7:0], in_if.rx_byte} > wsd_pkg::MAX_FRAME_BYTES))
                begin
                  phase_nxt   = PH_CLOSED;
                  push        = 1'b1;
                  cmd.kind    = wsd_pkg::KIND_PROTO;
                  cmd.closing = 1'b1;
                end else begin
                  pay_left_nxt = {len_acc_r[7:0], in_if.rx_byte};
                  mask_idx_nxt = 2'd0;
                  phase_nxt    = PH_MASK;
                end
              end
            end
            PH_MASK: begin
              mask_idx_nxt = mask_idx_r + 2'd1;
              push         = 1'b1;
              if (mask_idx_r == 2'd3 && pay_left_r == 16'd0) begin
                cmd.kind    = wsd_pkg::KIND_EMPTY;
                cmd.last    = 1'b1;
                cmd.closing = fin_close;
                phase_nxt   = fin_close ? PH_CLOSED : PH_HDR1;
                if (!fin_close) begin
                  idle_nxt = 16'd0;
                end
              end else begin
                cmd.cmd     = wsd_pkg::CMD_MASK;
                cmd.rx_val  = in_if.rx_byte;
                cmd.key_idx = mask_idx_r;
                if (mask_idx_r == 2'd3) begin
                  phase_nxt = PH_PAYLOAD;
                end
              end
            end
            PH_PAYLOAD: begin
              mask_idx_nxt = mask_idx_r + 2'd1;
              pay_left_nxt = pay_dec;
              push         = 1'b1;
              cmd.cmd      = wsd_pkg::CMD_DATA;
              cmd.kind     = wsd_pkg::KIND_DATA;
              cmd.rx_val   = in_if.rx_byte;
              cmd.key_idx  = mask_idx_r;
              if (pay_dec == 16'd0) begin
                cmd.last    = 1'b1;
                cmd.closing = fin_close;
                phase_nxt   = fin_close ? PH_CLOSED : PH_HDR1;
                if (!fin_close) begin
                  idle_nxt = 16'd0;
                end
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_STOPPED;
      opc_r        <= 4'd0;
      ext_left_r   <= 4'd0;
      len_acc_r    <= 16'd0;
      len_ovf_r    <= 1'b0;
      mask_idx_r   <= 2'd0;
      pay_left_r   <= 16'd0;
      idle_r       <= 16'd0;
      idle_limit_r <= wsd_pkg::IDLE_LIMIT_RST;
    end else begin
      phase_r    <= phase_nxt;
      opc_r      <= opc_nxt;
      ext_left_r <= ext_left_nxt;
      len_acc_r  <= len_acc_nxt;
      len_ovf_r  <= len_ovf_nxt;
      mask_idx_r <= mask_idx_nxt;
      pay_left_r <= pay_left_nxt;
      idle_r     <= idle_nxt;
      if (cfg_if.valid) begin
        idle_limit_r <= cfg_if.data;
      end
    end
  end

  a_close_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (push && cmd.closing) |=> (phase_r == PH_CLOSED))
    else $error("closing command without closed phase");

  a_push_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> accept)
    else $error("command pushed without accepted item");

endmodule

`default_nettype wire

/* rtl/core/wsd_queue.sv */
// Small command FIFO between the header parser and the output stage.
`default_nettype none

module wsd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire wsd_pkg::wsd_cmd_t  din,
  output logic                    has_room,
  input  wire logic               pop,
  output wsd_pkg::wsd_cmd_t       dout,
  output logic                    not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  wsd_pkg::wsd_cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign has_room  = (count_r != FULL_CNT);
  assign not_empty = (count_r != '0);
  assign do_push   = push & has_room;
  assign do_pop    = pop & not_empty;
  assign dout      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count past depth");

endmodule

`default_nettype wire

/* rtl/core/wsd_back.sv */
// Output stage: holds the mask key, unmasks payload and registers results.
`default_nettype none

module wsd_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire wsd_pkg::wsd_cmd_t  q_cmd,
  output logic                    pop,
  wsd_out_if.source               out_if
);

  logic [7:0] key_r [4];
  logic       out_valid_r;
  logic [2:0] out_kind_r;
  logic [7:0] out_data_r;
  logic       out_last_r;
  logic [3:0] out_opc_r;
  logic       out_close_r;
  logic       out_free;
  logic       is_mask;
  logic       load;

  assign out_free = !out_valid_r || out_if.ready;
  assign is_mask  = (q_cmd.cmd == wsd_pkg::CMD_MASK);
  assign pop      = q_valid && (is_mask || out_free);
  assign load     = q_valid && !is_mask && out_free;

  assign out_if.valid         = out_valid_r;
  assign out_if.kind          = out_kind_r;
  assign out_if.data_byte     = out_data_r;
  assign out_if.last_in_frame = out_last_r;
  assign out_if.opcode        = out_opc_r;
  assign out_if.closing       = out_close_r;

  always_ff @(posedge clk) begin
    if (q_valid && is_mask) begin
      key_r[q_cmd.key_idx] <= q_cmd.rx_val;
    end
    if (load) begin
      out_kind_r  <= q_cmd.kind;
      out_data_r  <= (q_cmd.cmd == wsd_pkg::CMD_DATA) ?
                     (q_cmd.rx_val ^ key_r[q_cmd.key_idx]) : 8'd0;
      out_last_r  <= q_cmd.last;
      out_opc_r   <= q_cmd.opcode;
      out_close_r <= q_cmd.closing;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= load;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("result popped but not presented");

  a_mask_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && is_mask && out_valid_r && !out_if.ready) |=> out_valid_r)
    else $error("key write disturbed the held result");

endmodule

`default_nettype wire

/* rtl/core/websocket_frame_deframer.sv */
// WebSocket client frame receiver with unmasking, top level.
// Channels: in_if carries one event per item (action: received byte, tick,
// link error or start) with rx_byte; out_if carries at most one result per
// input item (kind, data_byte, last_in_frame, opcode, closing); cfg_if writes
// the 16-bit header idle limit and is always ready.
// Throughput: one input item per cycle while the FIFO has room. The header parser updates its phase in
// the accept cycle and pushes a command into a QUEUE_DEPTH-entry FIFO; the
// output stage writes mask key bytes or registers a result from it.
// A result passes through the FIFO and then the output register before it appears on out_if.
// When out_if stalls, the output register holds its result, the FIFO fills and
// in_if.ready drops once the FIFO is full; mask bytes keep draining meanwhile.
// Reset: the link is stopped until a start item arrives; the idle limit
// returns to 15 and all queued commands and results are dropped.
`default_nettype none

module websocket_frame_deframer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wsd_in_if.sink     in_if,
  wsd_out_if.source  out_if,
  wsd_cfg_if.sink    cfg_if
);

  logic              push, q_room, q_valid, pop;
  wsd_pkg::wsd_cmd_t f_cmd, q_cmd;

  wsd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .cfg_if  (cfg_if),
    .q_ready (q_room),
    .push    (push),
    .cmd     (f_cmd)
  );

  wsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (f_cmd),
    .has_room  (q_room),
    .pop       (pop),
    .dout      (q_cmd),
    .not_empty (q_valid)
  );

  wsd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire

/* bench/websocket_frame_deframer_test.sv */
// Self-checking bench for the WebSocket frame deframer: random framed traffic, in-bench predictor.
`timescale 1ns / 100ps

module websocket_frame_deframer_test;

  typedef enum logic [1:0] {
    ACT_BYTE     = 2'd0,
    ACT_TICK     = 2'd1,
    ACT_LINK_ERR = 2'd2,
    ACT_START    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PH_STOPPED, PH_HDR1, PH_HDR2, PH_EXT, PH_MASK, PH_PAYLOAD, PH_CLOSED
  } link_phase_t;

  typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] rx_byte;
  } link_event_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       last_in_frame;
    logic [3:0] opcode;
    logic       closing;
  } frame_result_t;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int ITEMS_PER_PHASE = 45;

  logic clk = 1'b0;
  logic rst_n;

  wsd_in_if  in_bus ();
  wsd_out_if out_bus ();
  wsd_cfg_if cfg_bus ();

  websocket_frame_deframer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  link_event_t   tx_events[$];
  frame_result_t due_results[$];
  int            mismatches = 0;
  int            cycle_count = 0;
  int            in_gap = 0;
  int            out_stall = 0;
  bit            quiet_tail = 1'b0;
  logic          in_taken = 1'b0;
  int            gen_limit = 15;

  // predictor state
  link_phase_t link_phase = PH_STOPPED;
  logic [3:0]  cur_opcode = '0;
  logic [3:0]  ext_left = '0;
  logic [15:0] len_acc = '0;
  logic        len_over = 1'b0;
  logic [7:0]  key_bytes [4] = '{default: 8'h00};
  logic [1:0]  key_pos = '0;
  logic [15:0] bytes_left = '0;
  logic [15:0] idle_ticks = '0;
  logic [15:0] idle_limit = wsd_pkg::IDLE_LIMIT_RST;

  function automatic bit end_frame();
    if (cur_opcode == wsd_pkg::OPC_CLOSE) begin
      link_phase = PH_CLOSED;
      return 1'b1;
    end
    link_phase = PH_HDR1;
    idle_ticks = '0;
    return 1'b0;
  endfunction

  function automatic bit deframe_step(input action_t act, input logic [7:0] b,
                                      output frame_result_t res);
    bit active;
    active = link_phase != PH_STOPPED && link_phase != PH_CLOSED;
    res = '0;
    if (act == ACT_START) begin
      cur_opcode = '0;
      ext_left = '0;
      len_acc = '0;
      len_over = 1'b0;
      key_pos = '0;
      bytes_left = '0;
      idle_ticks = '0;
      link_phase = PH_HDR1;
      return 1'b0;
    end
    if (!active) return 1'b0;
    if (act == ACT_LINK_ERR) begin
      link_phase = PH_CLOSED;
      res.kind = wsd_pkg::KIND_LINK;
      res.closing = 1'b1;
      return 1'b1;
    end
    if (act == ACT_TICK) begin
      if (link_phase != PH_HDR1 && link_phase != PH_HDR2) return 1'b0;
      if (idle_ticks != 16'hffff) idle_ticks++;
      if (idle_ticks >= idle_limit) begin
        link_phase = PH_CLOSED;
        res.kind = wsd_pkg::KIND_TIMEOUT;
        res.closing = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    case (link_phase)
      PH_HDR1: begin
        cur_opcode = b[3:0];
        link_phase = PH_HDR2;
      end
      PH_HDR2: begin
        idle_ticks = '0;
        if (!b[7]) begin
          link_phase = PH_CLOSED;
          res.kind = wsd_pkg::KIND_PROTO;
          res.opcode = cur_opcode;
          res.closing = 1'b1;
          return 1'b1;
        end
        if (b[6:0] == wsd_pkg::LEN_EXT16 || b[6:0] == wsd_pkg::LEN_EXT64) begin
          ext_left = (b[6:0] == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_BYTES
                                                    : wsd_pkg::EXT64_BYTES;
          len_acc = '0;
          len_over = 1'b0;
          link_phase = PH_EXT;
        end else begin
          bytes_left = {9'd0, b[6:0]};
          key_pos = '0;
          link_phase = PH_MASK;
        end
      end
      PH_EXT: begin
        if (len_acc[15:8] != 8'd0) len_over = 1'b1;
        len_acc = {len_acc[7:0], b};
        if (ext_left != 4'd0) ext_left--;
        if (ext_left == 4'd0) begin
          if (len_over || len_acc > wsd_pkg::MAX_FRAME_BYTES) begin
            link_phase = PH_CLOSED;
            res.kind = wsd_pkg::KIND_PROTO;
            res.opcode = cur_opcode;
            res.closing = 1'b1;
            return 1'b1;
          end
          bytes_left = len_acc;
          key_pos = '0;
          link_phase = PH_MASK;
        end
      end
      PH_MASK: begin
        key_bytes[key_pos] = b;
        key_pos++;
        if (key_pos == 2'd0) begin
          if (bytes_left == 16'd0) begin
            res.kind = wsd_pkg::KIND_EMPTY;
            res.last_in_frame = 1'b1;
            res.opcode = cur_opcode;
            res.closing = end_frame();
            return 1'b1;
          end
          link_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.kind = wsd_pkg::KIND_DATA;
        res.data_byte = b ^ key_bytes[key_pos];
        res.opcode = cur_opcode;
        key_pos++;
        if (bytes_left != 16'd0) bytes_left--;
        if (bytes_left == 16'd0) begin
          res.last_in_frame = 1'b1;
          res.closing = end_frame();
        end
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // input driver
  always @(negedge clk) begin : feed_input
    logic        next_valid;
    link_event_t ev;
    next_valid = in_bus.valid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      if (in_bus.valid && in_taken) next_valid = 1'b0;
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (tx_events.size() > 0) begin
          ev = tx_events.pop_front();
          in_bus.action <= ev.action;
          in_bus.rx_byte <= ev.rx_byte;
          next_valid = 1'b1;
          if (!quiet_tail && $urandom_range(7) == 0) in_gap = $urandom_range(15, 1);
        end
      end
    end
    in_bus.valid <= next_valid;
  end

  // result back-pressure
  always @(negedge clk) begin : drain_output
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      if (!quiet_tail && $urandom_range(7) == 0) out_stall = $urandom_range(15, 1);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin : watch
    frame_result_t predicted;
    frame_result_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_bus.valid && in_bus.ready;
      if (cfg_bus.valid && cfg_bus.ready) idle_limit = cfg_bus.data;
      if (in_bus.valid && in_bus.ready) begin
        if (deframe_step(action_t'(in_bus.action), in_bus.rx_byte, predicted))
          due_results.push_back(predicted);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d data %0d", out_bus.kind, out_bus.data_byte);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", want.kind, out_bus.kind);
          check_field("data_byte", want.data_byte, out_bus.data_byte);
          check_field("last_in_frame", want.last_in_frame, out_bus.last_in_frame);
          check_field("opcode", want.opcode, out_bus.opcode);
          check_field("closing", want.closing, out_bus.closing);
        end
      end
    end
  end

  function automatic void queue_event(input action_t act, input logic [7:0] b);
    tx_events.push_back('{act, b});
  endfunction

  // one client frame; cut >= 0 keeps only that many leading items
  function automatic int build_frame(input logic [3:0] opc, input len_form_t form,
                                     input logic [63:0] len, input bit masked, input int cut);
    link_event_t evs[$];
    int          budget;
    int          pre;
    int          plen;
    logic [6:0]  len7;
    budget = (gen_limit > 1) ? gen_limit - 1 : 0;
    if (budget > 3) budget = 3;
    pre = $urandom_range(budget, 0);
    repeat (pre) evs.push_back('{ACT_TICK, 8'($urandom)});
    evs.push_back('{ACT_BYTE, {4'($urandom), opc}});
    repeat ($urandom_range(budget - pre, 0)) evs.push_back('{ACT_TICK, 8'($urandom)});
    case (form)
      FORM_EXT16: len7 = wsd_pkg::LEN_EXT16;
      FORM_EXT64: len7 = wsd_pkg::LEN_EXT64;
      default:    len7 = len[6:0];
    endcase
    evs.push_back('{ACT_BYTE, {masked, len7}});
    if (masked) begin
      if (form == FORM_EXT16) begin
        evs.push_back('{ACT_BYTE, len[15:8]});
        evs.push_back('{ACT_BYTE, len[7:0]});
      end else if (form == FORM_EXT64) begin
        for (int i = 7; i >= 0; i--) evs.push_back('{ACT_BYTE, len[i*8 +: 8]});
      end
      if (!(form == FORM_EXT64 && len[63:16] != '0)) begin
        repeat (4) evs.push_back('{ACT_BYTE, 8'($urandom)});
        plen = (form == FORM_SHORT) ? int'(len[6:0]) : int'(len[15:0]);
        for (int i = 0; i < plen; i++) begin
          if ($urandom_range(9) == 0) evs.push_back('{ACT_TICK, 8'($urandom)});
          evs.push_back('{ACT_BYTE, 8'($urandom)});
        end
      end
    end
    if (cut < 0 || cut > evs.size()) cut = evs.size();
    for (int i = 0; i < cut; i++) tx_events.push_back(evs[i]);
    return cut;
  endfunction

  // start, then frames until the link closes or the session ends
  function automatic int gen_session();
    int          made;
    int          n;
    int          r;
    int          r2;
    logic [3:0]  opc;
    logic [63:0] len;
    len_form_t   form;
    bit          closed;
    queue_event(ACT_START, 8'($urandom));
    made = 1;
    closed = 1'b0;
    n = $urandom_range(6, 1);
    for (int f = 0; f < n && !closed; f++) begin
      r = $urandom_range(99);
      opc = 4'($urandom);
      if (r < 72) begin
        r2 = $urandom_range(99);
        if (r2 < 55) begin
          form = FORM_SHORT;
          len = $urandom_range(12);
        end else if (r2 < 70) begin
          form = FORM_SHORT;
          len = $urandom_range(125, 13);
        end else if (r2 < 85) begin
          form = FORM_EXT16;
          len = $urandom_range(160);
        end else if (r2 < 93) begin
          form = FORM_EXT64;
          len = $urandom_range(40);
        end else begin
          form = FORM_EXT16;
          len = $urandom_range(3);
        end
        made += build_frame(opc, form, len, 1'b1, -1);
        closed = (opc == wsd_pkg::OPC_CLOSE);
      end else if (r < 79) begin
        made += build_frame(opc, FORM_SHORT, 64'($urandom_range(127)), 1'b0, -1);
        closed = 1'b1;
      end else if (r < 84) begin
        len = {$urandom, $urandom};
        if (len[63:16] == '0) len[40] = 1'b1;
        made += build_frame(opc, FORM_EXT64, len, 1'b1, -1);
        closed = 1'b1;
      end else if (r < 90) begin
        made += build_frame(opc, FORM_SHORT, 64'($urandom_range(20, 1)), 1'b1,
                            $urandom_range(6, 1));
        queue_event(ACT_LINK_ERR, 8'($urandom));
        made++;
        closed = 1'b1;
      end else if (r < 94) begin
        if (gen_limit <= 64) begin
          if ($urandom_range(1) == 1) begin
            queue_event(ACT_BYTE, 8'($urandom));
            made++;
          end
          repeat ((gen_limit == 0) ? 1 : gen_limit) begin
            queue_event(ACT_TICK, 8'($urandom));
            made++;
          end
          closed = 1'b1;
        end
      end else if (r < 97) begin
        made += build_frame(opc, FORM_SHORT, 64'($urandom_range(20)), 1'b1,
                            $urandom_range(6, 1));
        queue_event(ACT_START, 8'($urandom));
        made++;
      end else begin
        repeat ($urandom_range(4, 1)) begin
          queue_event(action_t'($urandom_range(3)), 8'($urandom));
          made++;
        end
        closed = 1'b1;
      end
    end
    // traffic after close is dropped by the block
    if (closed) begin
      repeat ($urandom_range(2)) queue_event(action_t'($urandom_range(2)), 8'($urandom));
    end
    return made;
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (tx_events.size() != 0 || in_bus.valid || due_results.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_idle_limit(input logic [15:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : run
    int limits[6];
    int made;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.action = ACT_BYTE;
    in_bus.rx_byte = 8'h00;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = 16'h0000;

    // ignored while stopped
    queue_event(ACT_BYTE, 8'hFF);
    queue_event(ACT_TICK, 8'h00);
    queue_event(ACT_LINK_ERR, 8'h00);
    // extended 16-bit form with a small length, opcode 0xF
    queue_event(ACT_START, 8'h00);
    queue_event(ACT_BYTE, 8'hFF);
    queue_event(ACT_BYTE, 8'hFE);
    queue_event(ACT_BYTE, 8'h00);
    queue_event(ACT_BYTE, 8'h03);
    queue_event(ACT_BYTE, 8'hFF);
    queue_event(ACT_BYTE, 8'h00);
    queue_event(ACT_BYTE, 8'hA5);
    queue_event(ACT_BYTE, 8'h5A);
    queue_event(ACT_BYTE, 8'h00);
    queue_event(ACT_BYTE, 8'hFF);
    queue_event(ACT_BYTE, 8'h0F);
    // empty close frame, then traffic on the closed link
    queue_event(ACT_BYTE, 8'h88);
    queue_event(ACT_BYTE, 8'h80);
    repeat (4) queue_event(ACT_BYTE, 8'($urandom));
    queue_event(ACT_BYTE, 8'h81);
    queue_event(ACT_TICK, 8'h00);
    // unmasked frame
    queue_event(ACT_START, 8'h00);
    queue_event(ACT_BYTE, 8'h02);
    queue_event(ACT_BYTE, 8'h7D);
    // 64-bit length too wide
    queue_event(ACT_START, 8'h00);
    queue_event(ACT_BYTE, 8'h00);
    queue_event(ACT_BYTE, 8'hFF);
    queue_event(ACT_BYTE, 8'h80);
    repeat (7) queue_event(ACT_BYTE, 8'h00);
    // restart mid-header, then link error
    queue_event(ACT_START, 8'h00);
    queue_event(ACT_BYTE, 8'h01);
    queue_event(ACT_START, 8'h00);
    queue_event(ACT_BYTE, 8'h0A);
    queue_event(ACT_LINK_ERR, 8'h00);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait_drained();

    limits[0] = wsd_pkg::IDLE_LIMIT_RST;
    limits[1] = 0;
    limits[2] = 1;
    limits[3] = $urandom_range(40, 2);
    limits[4] = 65535;
    limits[5] = $urandom_range(8, 2);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_idle_limit(16'(limits[ph]));
      end
      gen_limit = limits[ph];
      if (ph == 5) quiet_tail = 1'b1;
      made = 0;
      while (made < ITEMS_PER_PHASE) made += gen_session();
    end
    wait_drained();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && due_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
